// File: src/ppmsd_pkg.sv
// ----------------------------------------------------------------------------
// ppmsd_pkg
// Shared types, constants and the sRGB curve table for the PPM decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package ppmsd_pkg;

  localparam int DIM_BITS       = 16;
  localparam int CURVE_SEGMENTS = 256;
  localparam int IDX_W          = $clog2(CURVE_SEGMENTS + 1);
  localparam int P_W            = 16 + IDX_W;
  localparam logic [16:0] DIM_MAX = 17'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_BAD_MAGIC = 3'd1,
    KIND_BAD_HDR   = 3'd2,
    KIND_WIDE_P6   = 3'd3,
    KIND_TRUNC     = 3'd4,
    KIND_BAD_NUM   = 3'd5
  } kind_e;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic        is_err;
    kind_e       kind;
    logic [15:0] sample;
    logic [15:0] maxval;
    logic [1:0]  chan;
    logic [15:0] col;
    logic [15:0] row;
    logic        last;
  } job_t;

  typedef struct packed {
    logic s_vld;
    logic e_vld;
    job_t s_job;
    job_t e_job;
  } push_t;

  typedef logic [16:0] knot_t;
  typedef knot_t knot_tab_t [CURVE_SEGMENTS + 1];

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic longint unsigned fifth_pow(longint unsigned z);
    longint unsigned a;
    a = z;
    for (int k = 0; k < 4; k++) a = (a * z) >> 16;
    return a;
  endfunction

  function automatic knot_t curve_point(longint unsigned x);
    longint unsigned y, q, lo, hi, mid;
    lo = 0;
    hi = 65536;
    if (x <= 2650) return knot_t'((x * 25) / 323);
    y = (x * 1000 + 3604480) / 1055;
    q = (y * y) >> 16;
    for (int it = 0; it < 20; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fifth_pow(mid) <= q) lo = mid;
        else hi = mid - 1;
      end
    end
    return knot_t'((q * lo) >> 16);
  endfunction

  function automatic knot_tab_t build_knots();
    knot_tab_t t;
    for (int i = 0; i <= CURVE_SEGMENTS; i++)
      t[i] = curve_point((longint'(i) * 65536) / CURVE_SEGMENTS);
    return t;
  endfunction

  localparam knot_tab_t KNOTS = build_knots();

endpackage
`default_nettype wire

// File: src/ppmsd_if.sv
// ----------------------------------------------------------------------------
// ppmsd_if
// Byte input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppmsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       final_byte;
  modport source(output valid, data_byte, first_byte, final_byte, input ready);
  modport sink(input valid, data_byte, first_byte, final_byte, output ready);
endinterface

interface ppmsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [23:0] red_linear;
  logic [23:0] green_linear;
  logic [23:0] blue_linear;
  logic        last_pixel;
  modport source(output valid, kind, pixel_x, pixel_y, red_linear, green_linear,
                 blue_linear, last_pixel, input ready);
  modport sink(input valid, kind, pixel_x, pixel_y, red_linear, green_linear,
               blue_linear, last_pixel, output ready);
endinterface
`default_nettype wire

// File: src/ppmsd_front.sv
// ----------------------------------------------------------------------------
// ppmsd_front
// Header and sample parser: one byte per cycle while the queue has room, emits sample and error jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmsd_front import ppmsd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ppmsd_in_if.sink   in_i,
  input  wire logic  room_i,
  output push_t      push_o
);

  typedef enum logic [9:0] {
    PH_MAG0   = 10'b0000000001,
    PH_MAG1   = 10'b0000000010,
    PH_MAGEND = 10'b0000000100,
    PH_WID    = 10'b0000001000,
    PH_HGT    = 10'b0000010000,
    PH_MAXV   = 10'b0000100000,
    PH_P6DATA = 10'b0001000000,
    PH_P3DATA = 10'b0010000000,
    PH_DONE   = 10'b0100000000,
    PH_ERR    = 10'b1000000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        bin_q, bin_d, cm_q, cm_d, dg_q, dg_d;
  logic [16:0] acc_q, acc_d;
  logic [15:0] w_q, w_d, h_q, h_d, mx_q, mx_d, col_q, col_d, row_q, row_d;
  logic [1:0]  ch_q, ch_d;
  logic        accept;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid && room_i;

  always_comb begin
    logic [7:0]  c;
    logic        fin_byte, fin, pend_cm, s_req, err, numph;
    logic [15:0] s_v;
    logic [20:0] a;
    logic [16:0] num;
    logic [15:0] fin_val;
    kind_e       ekind;
    c = in_i.data_byte;
    phase_d = phase_q; bin_d = bin_q; cm_d = cm_q; dg_d = dg_q; acc_d = acc_q;
    w_d = w_q; h_d = h_q; mx_d = mx_q; col_d = col_q; row_d = row_q; ch_d = ch_q;
    if (in_i.first_byte) begin
      phase_d = PH_MAG0; bin_d = 1'b0; cm_d = 1'b0; dg_d = 1'b0; acc_d = '0;
      w_d = '0; h_d = '0; mx_d = '0; col_d = '0; row_d = '0; ch_d = '0;
    end
    fin_byte = 1'b0; pend_cm = 1'b0; s_req = 1'b0; s_v = '0;
    err = 1'b0; ekind = KIND_PIXEL; a = '0; num = '0;
    push_o = '0;

    // byte stage
    unique case (phase_d)
      PH_MAG0: begin
        if (c == CH_P) phase_d = PH_MAG1;
        else if (!is_blank(c)) begin err = 1'b1; ekind = KIND_BAD_MAGIC; end
      end
      PH_MAG1: begin
        if (c == CH_3 || c == CH_6) begin
          bin_d   = (c == CH_6);
          phase_d = PH_MAGEND;
        end else begin
          err = 1'b1; ekind = KIND_BAD_MAGIC;
        end
      end
      PH_MAGEND: begin
        if (is_blank(c)) phase_d = PH_WID;
        else begin err = 1'b1; ekind = KIND_BAD_MAGIC; end
      end
      PH_P6DATA: begin
        s_req = 1'b1;
        s_v   = {8'd0, c};
      end
      PH_WID, PH_HGT, PH_MAXV, PH_P3DATA: begin
        if (cm_d) begin
          if (c == CH_LF) cm_d = 1'b0;
        end else if (is_digit(c)) begin
          a     = {4'd0, acc_d} * 21'd10 + {13'd0, c - CH_0};
          acc_d = (a > 21'(ONE_Q16)) ? ONE_Q16 : a[16:0];
          dg_d  = 1'b1;
        end else if (phase_d == PH_MAXV && bin_d && dg_d) begin
          fin_byte = 1'b1;
        end else if (is_blank(c) || c == CH_HASH) begin
          if (dg_d) begin
            fin_byte = 1'b1;
            pend_cm  = (c == CH_HASH);
          end else if (c == CH_HASH) begin
            cm_d = 1'b1;
          end
        end else begin
          err = 1'b1; ekind = KIND_BAD_NUM;
        end
      end
      default: ;
    endcase
    if (err) phase_d = PH_ERR;

    // end of data completes a pending number
    numph = (phase_d == PH_WID) || (phase_d == PH_HGT) || (phase_d == PH_MAXV) ||
            (phase_d == PH_P3DATA);
    fin = fin_byte || (in_i.final_byte && numph && dg_d && !cm_d);

    // take the number, including a digit from this byte, before clearing
    if (fin) begin
      num   = acc_d;
      dg_d  = 1'b0;
      acc_d = '0;
      if (num[16]) begin
        err = 1'b1; ekind = KIND_BAD_NUM; phase_d = PH_ERR;
      end
    end
    fin_val = num[15:0];
    if (fin && !err) begin
      unique case (phase_d)
        PH_WID: begin w_d = fin_val; phase_d = PH_HGT; end
        PH_HGT: begin h_d = fin_val; phase_d = PH_MAXV; end
        PH_MAXV: begin
          mx_d = fin_val;
          if (w_d == '0 || {1'b0, w_d} > DIM_MAX || h_d == '0 ||
              {1'b0, h_d} > DIM_MAX || fin_val == '0) begin
            err = 1'b1; ekind = KIND_BAD_HDR; phase_d = PH_ERR;
          end else if (bin_d && fin_val > 16'd255) begin
            err = 1'b1; ekind = KIND_WIDE_P6; phase_d = PH_ERR;
          end else begin
            col_d = '0; row_d = '0; ch_d = '0;
            phase_d = bin_d ? PH_P6DATA : PH_P3DATA;
          end
        end
        PH_P3DATA: begin s_req = 1'b1; s_v = fin_val; end
        default: ;
      endcase
    end
    if (pend_cm && phase_d != PH_ERR) cm_d = 1'b1;

    if (s_req) begin
      push_o.s_vld        = accept;
      push_o.s_job.sample = s_v;
      push_o.s_job.maxval = mx_d;
      push_o.s_job.chan   = ch_d;
      push_o.s_job.kind   = KIND_PIXEL;
      if (ch_d != 2'd2) begin
        ch_d = ch_d + 2'd1;
      end else begin
        ch_d = '0;
        push_o.s_job.col  = col_d;
        push_o.s_job.row  = row_d;
        push_o.s_job.last = ({1'b0, col_d} + 17'd1 >= {1'b0, w_d}) &&
                            ({1'b0, row_d} + 17'd1 >= {1'b0, h_d});
        col_d = col_d + 16'd1;
        if (col_d >= w_d) begin
          col_d = '0;
          row_d = row_d + 16'd1;
          if (row_d >= h_d) phase_d = PH_DONE;
        end
      end
    end

    if (in_i.final_byte && !err && phase_d != PH_DONE && phase_d != PH_ERR) begin
      err = 1'b1; ekind = KIND_TRUNC; phase_d = PH_ERR;
    end
    push_o.e_vld         = accept && err;
    push_o.e_job.is_err  = 1'b1;
    push_o.e_job.kind    = ekind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAG0;
      bin_q <= 1'b0; cm_q <= 1'b0; dg_q <= 1'b0; acc_q <= '0;
      w_q <= '0; h_q <= '0; mx_q <= '0; col_q <= '0; row_q <= '0; ch_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bin_q <= bin_d; cm_q <= cm_d; dg_q <= dg_d; acc_q <= acc_d;
      w_q <= w_d; h_q <= h_d; mx_q <= mx_d; col_q <= col_d; row_q <= row_d;
      ch_q <= ch_d;
    end
  end

endmodule
`default_nettype wire

// File: src/ppmsd_queue.sv
// ----------------------------------------------------------------------------
// ppmsd_queue
// Short job queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmsd_queue import ppmsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      vld_o,
  output job_t      head_o,
  input  wire logic pop_i
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [QPTR_W-1:0] wp1;
  logic [1:0]        n_push;
  logic              do_pop;

  assign room_o = cnt_q <= QCNT_W'(QDEPTH - 2);
  assign vld_o  = cnt_q != '0;
  assign head_o = mem_q[rp_q];
  assign do_pop = pop_i && vld_o;
  assign n_push = {1'b0, push_i.s_vld} + {1'b0, push_i.e_vld};
  assign wp1    = wp_q + QPTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.s_vld) mem_q[wp_q] <= push_i.s_job;
    if (push_i.e_vld) mem_q[push_i.s_vld ? wp1 : wp_q] <= push_i.e_job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QPTR_W'(n_push);
      rp_q  <= rp_q + QPTR_W'(do_pop);
      cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// File: src/ppmsd_back.sv
// ----------------------------------------------------------------------------
// ppmsd_back
// Sample conversion: normalize by maxval, sRGB curve, scale, pack results.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmsd_back import ppmsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] scale_i,
  input  wire logic        vld_i,
  input  job_t             head_i,
  output logic             pop_o,
  ppmsd_out_if.source      out_o
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_DIV    = 5'b00010,
    B_INTERP = 5'b00100,
    B_SCALE  = 5'b01000,
    B_EMIT   = 5'b10000
  } bstate_e;

  bstate_e           st_q, st_d;
  job_t              job_q;
  logic [15:0]       rem_q;
  logic [16:0]       quo_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [16:0]       lin_q;
  logic [23:0]       res_q, held0_q, held1_q;
  logic              ovld_q;
  logic              out_free;

  // divider step
  logic [16:0] r2;
  logic        qbit;
  assign r2   = {rem_q, 1'b0};
  assign qbit = r2 >= {1'b0, job_q.maxval};

  // curve interpolation
  logic [P_W-1:0]   p;
  logic [IDX_W-1:0] idx;
  logic [15:0]      frac;
  logic [32:0]      dprod;
  logic [16:0]      lin_d;
  always_comb begin
    p     = P_W'(quo_q) * P_W'(CURVE_SEGMENTS);
    idx   = p[P_W-1:16];
    frac  = p[15:0];
    dprod = '0;
    if (idx >= IDX_W'(CURVE_SEGMENTS)) begin
      lin_d = KNOTS[CURVE_SEGMENTS];
    end else begin
      dprod = 33'(KNOTS[idx + IDX_W'(1)] - KNOTS[idx]) * 33'(frac);
      lin_d = KNOTS[idx] + dprod[32:16];
    end
  end

  // scale and saturate
  logic [32:0] sprod;
  logic [23:0] sat;
  assign sprod = 33'(lin_q) * 33'(scale_i);
  assign sat   = (sprod[32:8] > 25'hFFFFFF) ? 24'hFFFFFF : sprod[31:8];

  assign out_free = !ovld_q || out_o.ready;
  assign pop_o    = (st_q == B_IDLE) && vld_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (vld_i) begin
          if (head_i.is_err) st_d = B_EMIT;
          else if (head_i.sample >= head_i.maxval) st_d = B_INTERP;
          else st_d = B_DIV;
        end
      end
      B_DIV:    if (cnt_q == DCNT_W'(DIV_STEPS - 1)) st_d = B_INTERP;
      B_INTERP: st_d = B_SCALE;
      B_SCALE:  st_d = (job_q.chan == 2'd2) ? B_EMIT : B_IDLE;
      B_EMIT:   if (out_free) st_d = B_IDLE;
      default:  st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        job_q <= head_i;
        rem_q <= head_i.sample;
        quo_q <= ONE_Q16;
        cnt_q <= '0;
      end
      B_DIV: begin
        rem_q <= qbit ? 16'(r2 - {1'b0, job_q.maxval}) : r2[15:0];
        quo_q <= (cnt_q == '0) ? {16'd0, qbit} : {quo_q[15:0], qbit};
        cnt_q <= cnt_q + DCNT_W'(1);
      end
      B_INTERP: lin_q <= lin_d;
      B_SCALE: begin
        res_q <= sat;
        if (job_q.chan == 2'd0) held0_q <= sat;
        if (job_q.chan == 2'd1) held1_q <= sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_EMIT && out_free) ovld_q <= 1'b1;
      else if (out_o.ready) ovld_q <= 1'b0;
    end
  end

  // output register: holds one result while the next sample is worked on
  always_ff @(posedge clk_i) begin
    if (st_q == B_EMIT && out_free) begin
      out_o.kind         <= job_q.kind;
      out_o.pixel_x      <= job_q.is_err ? 16'd0 : job_q.col;
      out_o.pixel_y      <= job_q.is_err ? 16'd0 : job_q.row;
      out_o.red_linear   <= job_q.is_err ? 24'd0 : held0_q;
      out_o.green_linear <= job_q.is_err ? 24'd0 : held1_q;
      out_o.blue_linear  <= job_q.is_err ? 24'd0 : res_q;
      out_o.last_pixel   <= job_q.is_err ? 1'b0 : job_q.last;
    end
  end
  assign out_o.valid = ovld_q;

endmodule
`default_nettype wire

// File: src/ppm_stream_decoder_srgb_linear_core.sv
// ----------------------------------------------------------------------------
// ppm_stream_decoder_srgb_linear_core
// PPM P3/P6 byte stream decoder with sRGB-to-linear conversion and scaling.
// ----------------------------------------------------------------------------
// Throughput: the parser takes one byte per cycle while the job queue has room.
// Each sample goes through the converter steps in order: a bit-serial divide by
// maxval (skipped when the sample reaches maxval), curve, then scale; the third
// sample of a pixel then packs it for output, and error results go straight to
// output. The converter pops the next job only once it is back in idle.
// Reset: asynchronous, clears parser, queue and converter control; scale = 1.0.
`default_nettype none
module ppm_stream_decoder_srgb_linear_core import ppmsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  ppmsd_in_if.sink         in_i,
  ppmsd_out_if.source      out_o
);

  // intensity scale, unsigned Q8.8; the user must write it only while the block is idle (not enforced here)
  logic [15:0] scale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scale_q <= 16'd256;
    else if (cfg_we_i) scale_q <= cfg_wdata_i;
  end

  push_t push;
  logic  room, qvld, pop;
  job_t  head;

  // front: parse header and samples, one byte per cycle while the queue has room
  ppmsd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // queue: decouple parser from converter; a byte may push a sample and an error
  ppmsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .vld_o  (qvld),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: convert samples, assemble pixels, present results
  ppmsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .vld_i   (qvld),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

// File: src/ppmsd_checker.sv
// ----------------------------------------------------------------------------
// ppmsd_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none
module ppmsd_checker import ppmsd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [2:0]  kind_i,
  input wire logic [15:0] x_i,
  input wire logic [15:0] y_i,
  input wire logic [23:0] r_i,
  input wire logic [23:0] g_i,
  input wire logic [23:0] b_i,
  input wire logic        last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable({kind_i, x_i, y_i, r_i, g_i, b_i, last_i}))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> kind_i <= KIND_BAD_NUM) else $error("unknown result kind");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i != KIND_PIXEL |-> x_i == 0 && y_i == 0 && r_i == 0 &&
    g_i == 0 && b_i == 0 && !last_i) else $error("error result carries pixel data");

endmodule

bind ppm_stream_decoder_srgb_linear_core ppmsd_checker u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (out_o.valid),
  .ready_i (out_o.ready),
  .kind_i  (out_o.kind),
  .x_i     (out_o.pixel_x),
  .y_i     (out_o.pixel_y),
  .r_i     (out_o.red_linear),
  .g_i     (out_o.green_linear),
  .b_i     (out_o.blue_linear),
  .last_i  (out_o.last_pixel)
);
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PPM P3/P6 decoder with sRGB-to-linear output.
// Streams directed and random PPM files through the byte channel, predicts
// every pixel and error request, and checks each output field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import ppmsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // Parser phases of the local decoder model
  typedef enum int {
    ST_MAG0, ST_MAG1, ST_MAGEND, ST_WID, ST_HGT, ST_MAXV, ST_P6DATA, ST_P3DATA,
    ST_DONE, ST_ERR
  } phase_e;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [23:0] r;
    logic [23:0] g;
    logic [23:0] b;
    logic        last;
  } pixel_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       final_b;
  } byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;

  ppmsd_in_if  in_ch();
  ppmsd_out_if out_ch();

  ppm_stream_decoder_srgb_linear_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch), .out_o(out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model state
  int unsigned curve_tab [CURVE_SEGMENTS + 1];
  phase_e      phase;
  bit          binary_fmt, in_cmt, have_digits;
  int unsigned acc, img_w, img_h, max_v, col, row, chan;
  int unsigned held [2];
  int unsigned scale;
  int          step_results;

  pixel_t expected_q [$];
  byte_t  file_q [$];
  int     errors = 0;
  int     pixels_seen = 0, faults_seen = 0, bytes_sent = 0;
  int     cycles = 0;
  bit     calm = 1'b0;   // no idling on either side while set

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.first_byte = 1'b0;
    in_ch.final_byte = 1'b0;
    out_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------- curve --
  function automatic longint unsigned pow5(longint unsigned z);
    longint unsigned a;
    a = z;
    for (int k = 0; k < 4; k++) a = (a * z) >> 16;
    return a;
  endfunction

  function automatic int unsigned srgb_knot(longint unsigned x);
    longint unsigned y, q, lo, hi, mid;
    lo = 0;
    hi = 65536;
    if (x <= 2650) return int'((x * 25) / 323);
    y = (x * 1000 + 3604480) / 1055;
    q = (y * y) >> 16;
    // Binary search for the fifth root of q
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5(mid) <= q) lo = mid;
      else hi = mid - 1;
    end
    return int'((q * lo) >> 16);
  endfunction

  function automatic int unsigned linearize(int unsigned v);
    longint unsigned m, x, p, f, lin, r;
    int unsigned i;
    m = (max_v != 0) ? max_v : 1;
    x = (longint'(v) << 16) / m;
    if (x > 65536) x = 65536;
    p = x * CURVE_SEGMENTS;
    i = int'(p >> 16);
    f = p & 16'hFFFF;
    if (i >= CURVE_SEGMENTS) lin = curve_tab[CURVE_SEGMENTS];
    else lin = curve_tab[i] + (((curve_tab[i+1] - curve_tab[i]) * f) >> 16);
    r = (lin * scale) >> 8;
    return (r > 24'hFFFFFF) ? 24'hFFFFFF : int'(r);
  endfunction

  // --------------------------------------------------------------- parser --
  function automatic void push_result(int unsigned kind, int unsigned x, int unsigned y,
                                      int unsigned r, int unsigned g, int unsigned b,
                                      bit last);
    pixel_t e;
    if (step_results >= 2) return;
    e.kind = kind[2:0]; e.px = x[15:0]; e.py = y[15:0];
    e.r = r[23:0]; e.g = g[23:0]; e.b = b[23:0]; e.last = last;
    expected_q.push_back(e);
    step_results++;
  endfunction

  function automatic void raise_fault(kind_e k);
    push_result(k, 0, 0, 0, 0, 0, 1'b0);
    phase = ST_ERR;
  endfunction

  function automatic void clear_parse();
    phase = ST_MAG0;
    binary_fmt = 0; in_cmt = 0; acc = 0; have_digits = 0;
    img_w = 0; img_h = 0; max_v = 0; col = 0; row = 0; chan = 0;
    held[0] = 0; held[1] = 0;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void accept_sample(int unsigned v);
    int unsigned lin;
    bit last;
    lin = linearize(v);
    if (chan < 2) begin
      held[chan] = lin;
      chan++;
      return;
    end
    chan = 0;
    last = (col + 1 >= img_w) && (row + 1 >= img_h);
    push_result(KIND_PIXEL, col, row, held[0], held[1], lin, last);
    col++;
    if (col >= img_w) begin
      col = 0;
      row++;
      if (row >= img_h) phase = ST_DONE;
    end
  endfunction

  function automatic void close_number();
    int unsigned v;
    v = acc;
    acc = 0;
    have_digits = 0;
    if (v > 65535) begin
      raise_fault(KIND_BAD_NUM);
      return;
    end
    case (phase)
      ST_WID: begin img_w = v; phase = ST_HGT; end
      ST_HGT: begin img_h = v; phase = ST_MAXV; end
      ST_MAXV: begin
        max_v = v;
        if (img_w == 0 || img_w > DIM_MAX || img_h == 0 || img_h > DIM_MAX || max_v == 0)
          raise_fault(KIND_BAD_HDR);
        else if (binary_fmt && max_v > 255)
          raise_fault(KIND_WIDE_P6);
        else begin
          col = 0; row = 0; chan = 0;
          phase = binary_fmt ? ST_P6DATA : ST_P3DATA;
        end
      end
      ST_P3DATA: accept_sample(v);
      default: ;
    endcase
  endfunction

  function automatic bit numeric_phase();
    return phase == ST_WID || phase == ST_HGT || phase == ST_MAXV || phase == ST_P3DATA;
  endfunction

  function automatic void number_char(logic [7:0] c);
    int unsigned a;
    if (in_cmt) begin
      if (c == CH_LF) in_cmt = 0;
      return;
    end
    if (c >= CH_0 && c <= CH_9) begin
      a = acc * 10 + (c - CH_0);
      acc = (a > 65536) ? 65536 : a;
      have_digits = 1;
      return;
    end
    // In P6 any non-digit closes maxval and serves as the separator
    if (phase == ST_MAXV && binary_fmt && have_digits) begin
      close_number();
      return;
    end
    if (blank(c) || c == CH_HASH) begin
      if (have_digits) close_number();
      if (c == CH_HASH && phase != ST_ERR) in_cmt = 1;
      return;
    end
    raise_fault(KIND_BAD_NUM);
  endfunction

  // Advance the model by one accepted byte request
  function automatic void predict_byte(byte_t bt);
    logic [7:0] c;
    c = bt.data;
    step_results = 0;
    if (bt.first) clear_parse();
    case (phase)
      ST_MAG0:
        if (c == CH_P) phase = ST_MAG1;
        else if (!blank(c)) raise_fault(KIND_BAD_MAGIC);
      ST_MAG1:
        if (c == CH_3 || c == CH_6) begin
          binary_fmt = (c == CH_6);
          phase = ST_MAGEND;
        end else raise_fault(KIND_BAD_MAGIC);
      ST_MAGEND:
        if (blank(c)) phase = ST_WID;
        else raise_fault(KIND_BAD_MAGIC);
      ST_P6DATA: accept_sample(c);
      ST_DONE, ST_ERR: ;
      default: number_char(c);
    endcase
    // End of stream: flush a pending number, then flag an unfinished image
    if (bt.final_b && phase != ST_DONE && phase != ST_ERR) begin
      if (numeric_phase() && have_digits && !in_cmt) close_number();
      if (phase != ST_DONE && phase != ST_ERR) raise_fault(KIND_TRUNC);
    end
  endfunction

  // ------------------------------------------------------------- checking --
  always @(posedge clk_i) begin
    pixel_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d x=%0d y=%0d", $time, out_ch.kind,
                 out_ch.pixel_x, out_ch.pixel_y);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.kind == KIND_PIXEL) pixels_seen++;
        else faults_seen++;
        if (out_ch.kind !== e.kind || out_ch.pixel_x !== e.px || out_ch.pixel_y !== e.py ||
            out_ch.red_linear !== e.r || out_ch.green_linear !== e.g ||
            out_ch.blue_linear !== e.b || out_ch.last_pixel !== e.last) begin
          $display("%0t: mismatch expected kind=%0d x=%0d y=%0d r=%h g=%h b=%h last=%0d",
                   $time, e.kind, e.px, e.py, e.r, e.g, e.b, e.last);
          $display("%0t:          actual   kind=%0d x=%0d y=%0d r=%h g=%h b=%h last=%0d",
                   $time, out_ch.kind, out_ch.pixel_x, out_ch.pixel_y, out_ch.red_linear,
                   out_ch.green_linear, out_ch.blue_linear, out_ch.last_pixel);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------- driving --
  // Maybe idle for single cycles, then hold one byte request until accepted
  task automatic send_byte(byte_t bt);
    while (!calm && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= bt.data;
    in_ch.first_byte <= bt.first;
    in_ch.final_byte <= bt.final_b;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_byte(bt);
    bytes_sent++;
  endtask

  task automatic send_file();
    while (file_q.size() > 0) send_byte(file_q.pop_front());
  endtask

  function automatic void add_char(logic [7:0] c);
    byte_t bt;
    bt.data = c; bt.first = (file_q.size() == 0); bt.final_b = 1'b0;
    file_q.push_back(bt);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void mark_final();
    file_q[file_q.size() - 1].final_b = 1'b1;
  endfunction

  // Wait for every expected request, let the pipeline settle, then write the scale
  task automatic drain_and_set(int unsigned v);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale = v;
  endtask

  // ---------------------------------------------------------------- tests --
  task automatic test_p6_basic();
    add_text("P6 1 1 255 ");
    add_char(8'd0); add_char(8'd255); add_char(8'd128);
    send_file();
  endtask

  task automatic test_p3_clamp_and_flush();
    // Sample above maxval clamps; final byte flushes the pending number
    add_text("P3\n#c\n2 1 9\n0 5 9 12 3 7");
    mark_final();
    send_file();
  endtask

  task automatic test_faults();
    add_text("X"); send_file();
    add_text("P3 -"); send_file();
    add_text("P3 0 1 1 "); send_file();
    add_text("P6 1 1 256#"); send_file();
    add_text("P3 1 1 70000 "); send_file();
    add_text("P3 1 1 5 1"); mark_final(); send_file();
  endtask

  function automatic void add_sep();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) add_text(" # note\n");
    else if (sel == 1) add_char(8'(9 + $urandom_range(4)));
    else add_char(CH_SPACE);
  endfunction

  function automatic void add_num(int unsigned v);
    add_text($sformatf("%0d", v));
  endfunction

  // Build one random file: mostly well formed, some corrupted or cut short
  function automatic void build_random_file();
    bit p6;
    int unsigned w, h, mv, n, cut;
    p6 = 1'($urandom_range(1));
    w = $urandom_range(1, 3);
    h = $urandom_range(1, 2);
    case ($urandom_range(3))
      0: mv = 255;
      1: mv = $urandom_range(1, 255);
      2: mv = p6 ? $urandom_range(1, 300) : 65535;
      default: mv = p6 ? 255 : $urandom_range(1, 1000);
    endcase
    if ($urandom_range(7) == 0) add_char(CH_SPACE);
    add_text(p6 ? "P6" : "P3");
    add_sep(); add_num(w); add_sep(); add_num(h); add_sep(); add_num(mv);
    if (p6) add_char($urandom_range(3) == 0 ? CH_HASH : CH_LF);
    else add_sep();
    n = w * h * 3;
    for (int i = 0; i < n; i++) begin
      if (p6) add_char(8'($urandom_range(255)));
      else begin
        add_num($urandom_range(3) == 0 ? $urandom_range(mv + 10) : $urandom_range(mv));
        add_sep();
      end
    end
    case ($urandom_range(9))
      0, 1: file_q[$urandom_range(file_q.size() - 1)].data = 8'($urandom_range(255));
      2: begin
        cut = $urandom_range(1, file_q.size() - 1);
        while (file_q.size() > cut) void'(file_q.pop_back());
        mark_final();
      end
      3: file_q[0].first = 1'b0;
      default: ;
    endcase
    if ($urandom_range(1)) mark_final();
    // Trailing noise after the image is ignored until the next restart
    if ($urandom_range(4) == 0) add_char(8'($urandom_range(255)));
  endfunction

  task automatic test_random(int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (bytes_sent - start > budget / 3 && bytes_sent - start < budget / 2) calm = 1'b1;
      else calm = 1'b0;
      build_random_file();
      send_file();
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i <= CURVE_SEGMENTS; i++)
      curve_tab[i] = srgb_knot((longint'(i) * 65536) / CURVE_SEGMENTS);
    scale = 256;
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_p6_basic();
    test_p3_clamp_and_flush();
    test_faults();
    drain_and_set(16'hFFFF);
    test_p6_basic();
    drain_and_set(0);
    test_p6_basic();
    drain_and_set(256);
    test_random(300);
    drain_and_set(16'hFFFF);
    test_random(150);
    drain_and_set(0);
    test_random(100);
    drain_and_set($urandom_range(1, 65535));
    test_random(250);

    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d bytes over several scale settings; checked %0d pixels, %0d faults.",
             bytes_sent, pixels_seen, faults_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ppmsd_pkg.sv
src/ppmsd_if.sv
src/ppmsd_front.sv
src/ppmsd_queue.sv
src/ppmsd_back.sv
src/ppm_stream_decoder_srgb_linear_core.sv
src/ppmsd_checker.sv
bench/testbench.sv
